### sv/qts_pkg.sv
`default_nettype none

package qts_pkg;

   // Character codes with special meaning in quote mode
   localparam logic [7:0] CH_SLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE = 8'h22;

   // Register file layout
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_MASK_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_MASK_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_MASK_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_MASK_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_QUOTES   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TOKENS   = 3'd5;

   // Space (0x20) and tab (0x09)
   localparam logic [CSR_DATA_W-1:0] DELIM0_RESET = 64'h0000_0001_0000_0200;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       token_end;
      logic       string_done;
      logic       run_last;
   } rsp_type;

   // Up to two result words produced by one input word
   typedef struct packed {
      logic [1:0] cnt;
      rsp_type    r0;
      rsp_type    r1;
   } rsp_pair_type;

   typedef struct packed {
      logic [255:0] delim_mask;
      logic         use_quotes;
      logic [7:0]   max_tokens;
   } cfg_type;

endpackage

`default_nettype wire

### sv/qts_parser.sv
`default_nettype none

module qts_parser #(
   parameter int unsigned COUNT_WIDTH = 8
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   accept,
   input  qts_pkg::req_type      req_data,
   input  qts_pkg::cfg_type      cfg,
   output qts_pkg::rsp_pair_type pair
);
   import qts_pkg::*;

   localparam int unsigned LW = ((COUNT_WIDTH > 8) ? COUNT_WIDTH : 8) + 1;

   typedef enum logic [2:0] {
      PH_SKIP  = 3'b001,
      PH_TOKEN = 3'b010,
      PH_TAIL  = 3'b100
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic                   in_quote_ff, in_quote_in;
   logic                   slash_ff, slash_in;
   logic                   nonempty_ff, nonempty_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   function automatic rsp_pair_type put(rsp_pair_type p, logic [7:0] b, logic has,
                                        logic tend);
      rsp_pair_type q;
      rsp_type      r;
      q = p;
      r = '{out_byte: b, has_byte: has, token_end: tend, string_done: 1'b0,
            run_last: 1'b0};
      if (p.cnt == 2'd0) begin
         q.r0 = r;
      end else begin
         q.r1 = r;
      end
      q.cnt = p.cnt + 2'd1;
      return q;
   endfunction

   logic         is_delim;
   logic         limit;
   logic         tok;
   logic         do_end;
   logic [7:0]   b;
   rsp_pair_type p;

   assign b        = req_data.in_byte;
   assign is_delim = cfg.delim_mask[b];
   assign limit    = (cfg.max_tokens != 8'd0) &&
                     ((LW'(count_ff) + LW'(1)) >= LW'(cfg.max_tokens));

   // One byte through the splitter: results and next state
   always_comb begin
      phase_in    = phase_ff;
      in_quote_in = in_quote_ff;
      slash_in    = slash_ff;
      nonempty_in = nonempty_ff;
      count_in    = count_ff;
      p           = '0;
      tok         = 1'b0;
      do_end      = 1'b0;

      unique case (phase_ff)
         PH_TAIL: begin
            p           = put(p, b, 1'b1, 1'b0);
            nonempty_in = 1'b1;
         end
         PH_TOKEN: begin
            tok = 1'b1;
         end
         PH_SKIP: begin
            if (!is_delim) begin
               if (limit) begin
                  phase_in    = PH_TAIL;
                  p           = put(p, b, 1'b1, 1'b0);
                  nonempty_in = 1'b1;
               end else begin
                  phase_in = PH_TOKEN;
                  tok      = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_SKIP;
         end
      endcase

      // Token body with escape handling
      if (tok) begin
         priority if (is_delim && !in_quote_ff) begin
            do_end = 1'b1;
         end else if (!cfg.use_quotes) begin
            p           = put(p, b, 1'b1, 1'b0);
            nonempty_in = 1'b1;
         end else if (b == CH_SLASH) begin
            if (slash_ff) begin
               p           = put(p, b, 1'b1, 1'b0);
               nonempty_in = 1'b1;
               slash_in    = 1'b0;
            end else begin
               slash_in = 1'b1;
            end
         end else if (b == CH_QUOTE) begin
            if (slash_ff) begin
               p           = put(p, b, 1'b1, 1'b0);
               nonempty_in = 1'b1;
               slash_in    = 1'b0;
            end else begin
               do_end      = 1'b1;
               in_quote_in = ~in_quote_ff;
            end
         end else begin
            if (slash_ff) begin
               p        = put(p, CH_SLASH, 1'b1, 1'b0);
               slash_in = 1'b0;
            end
            p           = put(p, b, 1'b1, 1'b0);
            nonempty_in = 1'b1;
         end
      end

      // Close the token; a dangling backslash is dropped
      if (do_end) begin
         if (nonempty_in) begin
            p = put(p, 8'h00, 1'b0, 1'b1);
            if (count_in != '1) begin
               count_in = count_in + COUNT_WIDTH'(1);
            end
         end
         nonempty_in = 1'b0;
         slash_in    = 1'b0;
         phase_in    = PH_SKIP;
      end

      // End of string: close open token, mark done, back to reset state
      if (req_data.end_of_string) begin
         if ((phase_in != PH_SKIP) && nonempty_in) begin
            if (p.cnt == 2'd0) begin
               p = put(p, 8'h00, 1'b0, 1'b1);
            end else if (p.cnt == 2'd1) begin
               p.r0.token_end = 1'b1;
            end else begin
               p.r1.token_end = 1'b1;
            end
         end
         if (p.cnt == 2'd0) begin
            p = put(p, 8'h00, 1'b0, 1'b0);
         end
         if (p.cnt == 2'd1) begin
            p.r0.string_done = 1'b1;
         end else begin
            p.r1.string_done = 1'b1;
         end
         phase_in    = PH_SKIP;
         in_quote_in = 1'b0;
         slash_in    = 1'b0;
         nonempty_in = 1'b0;
         count_in    = '0;
      end

      if (p.cnt == 2'd1) begin
         p.r0.run_last = 1'b1;
      end else if (p.cnt == 2'd2) begin
         p.r1.run_last = 1'b1;
      end
   end

   assign pair = p;

   // Splitter state, updated per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SKIP;
         in_quote_ff <= 1'b0;
         slash_ff    <= 1'b0;
         nonempty_ff <= 1'b0;
         count_ff    <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         in_quote_ff <= in_quote_in;
         slash_ff    <= slash_in;
         nonempty_ff <= nonempty_in;
         count_ff    <= count_in;
      end
   end

endmodule

`default_nettype wire

### sv/qts_out_buf.sv
`default_nettype none

module qts_out_buf (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  qts_pkg::rsp_pair_type pair,
   output logic                  push_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output qts_pkg::rsp_type      rsp_data
);
   import qts_pkg::*;

   logic [1:0] count_ff, count_in;
   rsp_type    head_ff, head_in;
   rsp_type    second_ff, second_in;
   logic       pop;

   assign rsp_valid  = (count_ff != 2'd0);
   assign rsp_data   = head_ff;
   assign pop        = rsp_valid && rsp_ready;
   // Room for two words once the head leaves
   assign push_ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);

   // Two-slot shift buffer: head drives the port, second waits behind it
   always_comb begin
      count_in  = count_ff;
      head_in   = head_ff;
      second_in = second_ff;
      if (push) begin
         count_in  = pair.cnt;
         head_in   = pair.r0;
         second_in = pair.r1;
      end else if (pop) begin
         count_in = count_ff - 2'd1;
         head_in  = second_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff   <= head_in;
      second_ff <= second_in;
   end

endmodule

`default_nettype wire

### sv/quoted_token_splitter.sv
`default_nettype none

// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_ready  req_type (in_byte, end_of_string)
// rsp_      out        rsp_valid/rsp_ready  rsp_type (out_byte, flags)
// csr_      in         csr_we               csr_index, csr_wdata (64 bits)
//
// One input word per cycle while req_ready is high; its results enter a two-slot
// output buffer at the accepting edge and can leave from the next edge on. A byte
// that yields two words (backslash before an ordinary byte) sends them out one at a
// time through the single output port.
// Synchronous active-high reset clears splitter state and restores registers.
// req_ready drops while the buffer cannot take two more words.

module quoted_token_splitter #(
   parameter int unsigned COUNT_WIDTH = 8
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  qts_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output qts_pkg::rsp_type                   rsp_data,
   input  wire                                csr_we,
   input  wire [qts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire [qts_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import qts_pkg::*;

   logic [CSR_DATA_W-1:0] delim_ff [4];
   logic                  use_quotes_ff;
   logic [7:0]            max_tokens_ff;
   cfg_type               cfg;
   rsp_pair_type          pair;
   logic                  accept;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff[0]   <= DELIM0_RESET;
         delim_ff[1]   <= '0;
         delim_ff[2]   <= '0;
         delim_ff[3]   <= '0;
         use_quotes_ff <= 1'b1;
         max_tokens_ff <= 8'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DELIM_MASK_0: delim_ff[0] <= csr_wdata;
            CSR_DELIM_MASK_1: delim_ff[1] <= csr_wdata;
            CSR_DELIM_MASK_2: delim_ff[2] <= csr_wdata;
            CSR_DELIM_MASK_3: delim_ff[3] <= csr_wdata;
            CSR_USE_QUOTES:   use_quotes_ff <= csr_wdata[0];
            CSR_MAX_TOKENS:   max_tokens_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg.delim_mask = {delim_ff[3], delim_ff[2], delim_ff[1], delim_ff[0]};
   assign cfg.use_quotes = use_quotes_ff;
   assign cfg.max_tokens = max_tokens_ff;

   assign accept = req_valid && req_ready;

   qts_parser #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .cfg      (cfg),
      .pair     (pair)
   );

   qts_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .pair       (pair),
      .push_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // End of string always yields at least one word
   a_eos_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.end_of_string |-> (pair.cnt != 2'd0))
      else $error("end of string produced no result word");

   // Done mark only on the last word of an input
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.string_done |-> rsp_data.run_last)
      else $error("string_done without run_last");

   // Words without a byte carry a zero byte
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_byte |-> (rsp_data.out_byte == 8'h00))
      else $error("out_byte nonzero with has_byte low");

   // Taking a new word with a buffered one means that one is the last, leaving now
   a_ready_drain: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_ready && rsp_data.run_last)
      else $error("input taken while buffer cannot drain");

endmodule

`default_nettype wire

### test/tb_quoted_token_splitter.sv
`timescale 1ns / 100ps

module tb_quoted_token_splitter;
   import qts_pkg::*;

   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned SETTLE      = 6;
   localparam logic [7:0]  SPACE       = 8'h20;
   localparam logic [7:0]  TAB         = 8'h09;
   localparam int unsigned IDLE_PCT    = 38;

   typedef enum logic [1:0] {SPLIT_SKIP, SPLIT_TOKEN, SPLIT_TAIL} split_phase_type;

   // Block ports; the inputs driven here are known from time zero
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Splitter shadow: registers and state
   logic [63:0]            delim_mask_q [4];
   logic                   quotes_on;
   logic [7:0]             token_limit;
   split_phase_type        split_phase;
   logic                   quoted;
   logic                   slash_held;
   logic                   token_open;
   logic [COUNT_W-1:0]     tokens_done;

   // Words produced by the word being predicted, then the queue of pending words
   rsp_type                step_buf [2];
   int                     step_n;
   rsp_type                expected_words [$];

   int                     fail_count = 0;
   int unsigned            idle_pct = IDLE_PCT;
   logic                   hold_off_request = 1'b0;
   int unsigned            hold_left = 0;

   quoted_token_splitter #(
      .COUNT_WIDTH (COUNT_W)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   //------------------------------------------------------------------
   // Splitter shadow
   //------------------------------------------------------------------

   function automatic void clear_split_state();
      split_phase = SPLIT_SKIP;
      quoted      = 1'b0;
      slash_held  = 1'b0;
      token_open  = 1'b0;
      tokens_done = '0;
   endfunction

   function automatic void reset_shadow();
      delim_mask_q[0] = DELIM0_RESET;
      delim_mask_q[1] = '0;
      delim_mask_q[2] = '0;
      delim_mask_q[3] = '0;
      quotes_on       = 1'b1;
      token_limit     = '0;
      clear_split_state();
   endfunction

   function automatic logic is_delim(logic [7:0] b);
      return delim_mask_q[b[7:6]][b[5:0]];
   endfunction

   function automatic void emit(logic [7:0] b, logic has, logic tend);
      rsp_type w;
      w           = '0;
      w.out_byte  = b;
      w.has_byte  = has;
      w.token_end = tend;
      step_buf[step_n] = w;
      step_n++;
   endfunction

   function automatic void emit_byte(logic [7:0] b);
      emit(b, 1'b1, 1'b0);
      token_open = 1'b1;
   endfunction

   // Close the current token; empty tokens leave no trace
   function automatic void close_token();
      if (token_open) begin
         emit(8'h00, 1'b0, 1'b1);
         if (tokens_done != '1)
            tokens_done = tokens_done + COUNT_W'(1);
      end
      token_open  = 1'b0;
      slash_held  = 1'b0;
      split_phase = SPLIT_SKIP;
   endfunction

   function automatic logic limit_hit();
      return token_limit != 0 && (32'(tokens_done) + 32'd1) >= 32'(token_limit);
   endfunction

   function automatic void token_step(logic [7:0] b, logic d);
      if (d && !quoted) begin
         close_token();
      end else if (!quotes_on) begin
         emit_byte(b);
      end else if (b == CH_SLASH) begin
         if (slash_held) begin
            emit_byte(b);
            slash_held = 1'b0;
         end else begin
            slash_held = 1'b1;
         end
      end else if (b == CH_QUOTE) begin
         if (slash_held) begin
            emit_byte(b);
            slash_held = 1'b0;
         end else begin
            close_token();
            quoted = ~quoted;
         end
      end else begin
         // backslash before an ordinary byte is kept literally
         if (slash_held) begin
            emit_byte(CH_SLASH);
            slash_held = 1'b0;
         end
         emit_byte(b);
      end
   endfunction

   function automatic void predict_words(req_type w);
      logic [7:0] b;
      logic       d;
      b      = w.in_byte;
      d      = is_delim(b);
      step_n = 0;
      case (split_phase)
         SPLIT_TAIL: begin
            emit_byte(b);
         end
         SPLIT_TOKEN: begin
            token_step(b, d);
         end
         default: begin
            if (!d) begin
               if (limit_hit()) begin
                  split_phase = SPLIT_TAIL;
                  emit_byte(b);
               end else begin
                  split_phase = SPLIT_TOKEN;
                  token_step(b, d);
               end
            end
         end
      endcase
      if (w.end_of_string) begin
         if (split_phase != SPLIT_SKIP && token_open) begin
            if (step_n > 0)
               step_buf[step_n-1].token_end = 1'b1;
            else
               emit(8'h00, 1'b0, 1'b1);
         end
         if (step_n == 0)
            emit(8'h00, 1'b0, 1'b0);
         step_buf[step_n-1].string_done = 1'b1;
         clear_split_state();
      end
      if (step_n > 0)
         step_buf[step_n-1].run_last = 1'b1;
      for (int i = 0; i < step_n; i++)
         expected_words = {expected_words, step_buf[i]};
   endfunction

   //------------------------------------------------------------------
   // Drivers
   //------------------------------------------------------------------

   // Offer one word, idling first at random; valid stays up after acceptance
   task automatic send_word(logic [7:0] b, logic eos);
      req_type w;
      w.in_byte       = b;
      w.end_of_string = eos;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do
         @(posedge clock);
      while (!req_ready);
      predict_words(w);
   endtask

   task automatic send_text(string s, logic eos_at_end);
      for (int i = 0; i < s.len(); i++)
         send_word(s[i], eos_at_end && i == s.len() - 1);
   endtask

   // Stop offering and let every pending word come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_DELIM_MASK_0: delim_mask_q[0] = data;
         CSR_DELIM_MASK_1: delim_mask_q[1] = data;
         CSR_DELIM_MASK_2: delim_mask_q[2] = data;
         CSR_DELIM_MASK_3: delim_mask_q[3] = data;
         CSR_USE_QUOTES:   quotes_on       = data[0];
         CSR_MAX_TOKENS:   token_limit     = data[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(logic [63:0] m0, logic [63:0] m1, logic [63:0] m2,
                               logic [63:0] m3, logic uq, logic [7:0] mt);
      wait_idle();
      write_reg(CSR_DELIM_MASK_0, m0);
      write_reg(CSR_DELIM_MASK_1, m1);
      write_reg(CSR_DELIM_MASK_2, m2);
      write_reg(CSR_DELIM_MASK_3, m3);
      write_reg(CSR_USE_QUOTES, {63'b0, uq});
      write_reg(CSR_MAX_TOKENS, {56'b0, mt});
   endtask

   //------------------------------------------------------------------
   // Stimulus helpers
   //------------------------------------------------------------------

   function automatic logic [63:0] sparse_mask();
      return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
   endfunction

   function automatic logic [7:0] delim_byte();
      logic [7:0] b;
      for (int k = 0; k < 16; k++) begin
         b = 8'($urandom_range(255));
         if (is_delim(b))
            return b;
      end
      return ($urandom_range(1) != 0) ? SPACE : TAB;
   endfunction

   // Text-like byte mix: delimiters, quotes, backslashes, letters, anything
   function automatic logic [7:0] text_byte();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 22)
         return delim_byte();
      else if (r < 34)
         return CH_QUOTE;
      else if (r < 46)
         return CH_SLASH;
      else if (r < 85)
         return 8'h61 + 8'($urandom_range(25));
      else
         return 8'($urandom_range(255));
   endfunction

   task automatic send_strings(int n_items);
      int   sent;
      int   len;
      logic noise;
      sent = 0;
      while (sent < n_items) begin
         len   = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
         noise = ($urandom_range(6) == 0);
         for (int i = 0; i < len; i++)
            send_word(noise ? 8'($urandom_range(255)) : text_byte(), i == len - 1);
         sent += len;
      end
   endtask

   //------------------------------------------------------------------
   // Tests
   //------------------------------------------------------------------

   // Leading delimiters, escapes, literal and dangling backslash, empty and
   // quoted tokens, extreme byte values, end of string with and without an open token
   task automatic test_directed();
      send_text("\t a\\\"b\\\\c\\d \"\" \"x y\"", 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(CH_SLASH, 1'b0);
      send_word(SPACE, 1'b1);
      send_word(SPACE, 1'b1);
      send_word(8'h00, 1'b1);
   endtask

   task automatic test_random_configs();
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: apply_config(DELIM0_RESET, '0, '0, '0, 1'b1, 8'd0);
            1: apply_config(DELIM0_RESET, '0, '0, '0, 1'b1, 8'd3);
            2: apply_config(DELIM0_RESET, '0, '0, '0, 1'b0, 8'd0);
            3: apply_config(sparse_mask(), sparse_mask(), sparse_mask(), sparse_mask(),
                            1'b1, 8'd1);
            4: apply_config('0, '0, '0, '0, 1'b1, 8'd255);
            5: apply_config(sparse_mask(), sparse_mask(), sparse_mask(), sparse_mask(),
                            1'($urandom_range(1)), 8'($urandom_range(6)));
            6: apply_config('1, '1, '1, '1, 1'b1, 8'd2);
            default: apply_config({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, 8'd4);
         endcase
         // one phase runs with no idling on either side
         idle_pct = (p == 2) ? 0 : IDLE_PCT;
         send_strings(50);
      end
      idle_pct = IDLE_PCT;
   endtask

   // Receiver holds off while the sender keeps offering words
   task automatic test_backpressure();
      apply_config(DELIM0_RESET, '0, '0, '0, 1'b1, 8'd0);
      idle_pct         = 0;
      hold_off_request = 1'b1;
      send_strings(80);
      idle_pct         = IDLE_PCT;
   endtask

   // Run the counter past its top, then lower the limit mid-string: a
   // saturated count puts the rest of the string into the raw tail
   task automatic test_count_saturation();
      apply_config(DELIM0_RESET, '0, '0, '0, 1'b1, 8'd0);
      for (int t = 0; t < 258; t++) begin
         send_word(8'h61 + 8'($urandom_range(25)), 1'b0);
         send_word(SPACE, 1'b0);
      end
      wait_idle();
      write_reg(CSR_MAX_TOKENS, 64'd255);
      send_text("bc d", 1'b1);
   endtask

   //------------------------------------------------------------------
   // Receiver and checker
   //------------------------------------------------------------------

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_words
      rsp_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: %h", rsp_data);
            fail_count++;
         end else begin
            exp_w = expected_words.pop_front();
            check_field("out_byte", exp_w.out_byte, rsp_data.out_byte);
            check_field("has_byte", 8'(exp_w.has_byte), 8'(rsp_data.has_byte));
            check_field("token_end", 8'(exp_w.token_end), 8'(rsp_data.token_end));
            check_field("string_done", 8'(exp_w.string_done), 8'(rsp_data.string_done));
            check_field("run_last", 8'(exp_w.run_last), 8'(rsp_data.run_last));
         end
      end
   end

   //------------------------------------------------------------------
   // Sequence
   //------------------------------------------------------------------

   initial begin
      reset_shadow();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_configs();
      test_backpressure();
      test_count_saturation();
      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("** quoted_token_splitter: PASSED **");
      else
         $display("** quoted_token_splitter: FAILED **");
      $finish;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("** quoted_token_splitter: FAILED **");
      $finish;
   end

endmodule

### sim.f
sv/qts_pkg.sv
sv/qts_parser.sv
sv/qts_out_buf.sv
sv/quoted_token_splitter.sv
test/tb_quoted_token_splitter.sv
